@@ design/tt_pkg.sv @@
`timescale 1ns / 1ps

package tt_pkg;

    typedef enum logic [2:0]
    {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_SYNTAX = 3'd4
    } mode_t;

    localparam logic [2:0] KIND_STRING  = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_SYNTAX  = 3'd2;
    localparam logic [2:0] KIND_NUMBER  = 3'd3;
    localparam logic [2:0] KIND_EOF     = 3'd4;
    localparam logic [2:0] KIND_NEWLINE = 3'd5;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed
    {
        logic       func;
        logic [7:0] text_byte;
    } in_word_t;

    typedef struct packed
    {
        logic [2:0]  token_kind;
        logic [15:0] begin_offset;
        logic [15:0] end_offset;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic        last_result;
    } out_word_t;

    typedef struct packed
    {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } scan_result_t;

endpackage

@@ design/text_tokenizer.sv @@
`timescale 1ns / 1ps

// Channel  Role    Handshake                  Payload
// byte     input   byte_valid / byte_ready    tt_pkg::in_word_t  (func, text_byte)
// token    output  token_valid / token_ready  tt_pkg::out_word_t (token descriptor)
//
// A byte is taken into the input register, scanned combinationally from there, and its
// token words are registered into the result buffer when the scanner steps on it.
// One byte per cycle is sustained while token_ready is high; after a byte that gives two
// words, the next byte with words waits until the buffer pops its last word (one a cycle).
// Reset puts the scanner at offset 0, line 1, column 1 with no open token.
// A stalled token channel stops the scanner only when a byte has words to deliver.

module text_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  tt_pkg::in_word_t  byte_word,
    output logic              token_valid,
    input  logic              token_ready,
    output tt_pkg::out_word_t token_word
);

    logic                 in_valid_reg;
    tt_pkg::in_word_t     in_word_reg;
    tt_pkg::scan_result_t result;
    logic                 can_load;
    logic                 advance;

    assign advance    = in_valid_reg && ((result.count == 2'd0) || can_load);
    assign byte_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_word_reg <= byte_word;
        end
    end

    tt_scanner #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scanner (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .result (result)
    );

    tt_result_buffer u_result_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && (result.count != 2'd0)),
        .result      (result),
        .can_load    (can_load),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_word  (token_word)
    );

endmodule

@@ design/tt_scanner.sv @@
`timescale 1ns / 1ps

module tt_scanner #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  tt_pkg::in_word_t     word,
    output tt_pkg::scan_result_t result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    tt_pkg::mode_t            mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tbeg_reg, tbeg_next;
    logic [15:0]              line_reg, line_next;
    logic [15:0]              col_reg, col_next;
    logic [15:0]              tline_reg, tline_next;
    logic [15:0]              tcol_reg, tcol_next;

    function automatic logic [15:0] sat16(input logic [POSITION_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POSITION_BITS'(1);
    endfunction

    function automatic logic [15:0] count_inc(input logic [15:0] v);
        return (v == tt_pkg::COUNT_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [2:0] mode_kind(input tt_pkg::mode_t m);
        logic [2:0] k;
        case (m)
            tt_pkg::MODE_IDENT:  k = tt_pkg::KIND_IDENT;
            tt_pkg::MODE_NUMBER: k = tt_pkg::KIND_NUMBER;
            tt_pkg::MODE_STRING: k = tt_pkg::KIND_STRING;
            default:             k = tt_pkg::KIND_SYNTAX;
        endcase
        return k;
    endfunction

    logic [7:0] c;
    logic       is_end, c_digit, c_alpha, c_alnum, c_space, c_nl, c_quote;
    logic       cont, quote_close, closing, opening;

    assign c       = word.text_byte;
    assign is_end  = word.func || (c == tt_pkg::CHAR_NUL);
    assign c_digit = (c >= 8'h30) && (c <= 8'h39);
    assign c_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    assign c_alnum = c_digit || c_alpha;
    assign c_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    assign c_nl    = (c == tt_pkg::CHAR_LF);
    assign c_quote = (c == tt_pkg::CHAR_QUOTE);

    always_comb
    begin
        case (mode_reg)
            tt_pkg::MODE_IDENT:  cont = c_alnum;
            tt_pkg::MODE_NUMBER: cont = c_digit;
            tt_pkg::MODE_STRING: cont = !c_quote;
            tt_pkg::MODE_SYNTAX: cont = !c_space && !c_alnum && !c_quote
                                        && (c != tt_pkg::CHAR_RPAREN)
                                        && (c != tt_pkg::CHAR_DOT)
                                        && (c != tt_pkg::CHAR_LPAREN);
            default:             cont = 1'b0;
        endcase
    end

    assign quote_close = !is_end && (mode_reg == tt_pkg::MODE_STRING) && c_quote;
    assign closing     = (mode_reg != tt_pkg::MODE_IDLE) && (mode_reg != tt_pkg::MODE_STRING)
                         && !cont;
    assign opening     = (mode_reg == tt_pkg::MODE_IDLE) || closing;

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        tbeg_next  = tbeg_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        if (is_end)
        begin
            mode_next  = tt_pkg::MODE_IDLE;
            pos_next   = '0;
            tbeg_next  = '0;
            line_next  = 16'd1;
            col_next   = 16'd1;
            tline_next = 16'd1;
            tcol_next  = 16'd1;
        end
        else
        begin
            if (quote_close)
            begin
                mode_next = tt_pkg::MODE_IDLE;
            end
            else if (opening)
            begin
                if (c_nl || c_space)
                begin
                    mode_next = tt_pkg::MODE_IDLE;
                end
                else
                begin
                    if (c_quote)
                    begin
                        mode_next = tt_pkg::MODE_STRING;
                    end
                    else if (c_alpha)
                    begin
                        mode_next = tt_pkg::MODE_IDENT;
                    end
                    else if (c_digit)
                    begin
                        mode_next = tt_pkg::MODE_NUMBER;
                    end
                    else
                    begin
                        mode_next = tt_pkg::MODE_SYNTAX;
                    end
                    tbeg_next  = pos_reg;
                    tline_next = line_reg;
                    tcol_next  = col_reg;
                end
            end
            if (c_nl)
            begin
                line_next = count_inc(line_reg);
                col_next  = 16'd1;
            end
            else
            begin
                col_next = count_inc(col_reg);
            end
            pos_next = pos_inc(pos_reg);
        end
    end

    always_comb
    begin
        tt_pkg::out_word_t open_word, eof_word, nl_word;

        open_word.token_kind   = mode_kind(mode_reg);
        open_word.begin_offset = sat16(tbeg_reg);
        open_word.end_offset   = quote_close ? sat16(pos_inc(pos_reg)) : sat16(pos_reg);
        open_word.start_line   = tline_reg;
        open_word.start_column = tcol_reg;
        open_word.last_result  = 1'b0;

        eof_word.token_kind   = tt_pkg::KIND_EOF;
        eof_word.begin_offset = sat16(pos_reg);
        eof_word.end_offset   = sat16(pos_reg);
        eof_word.start_line   = line_reg;
        eof_word.start_column = col_reg;
        eof_word.last_result  = 1'b1;

        nl_word.token_kind   = tt_pkg::KIND_NEWLINE;
        nl_word.begin_offset = sat16(pos_reg);
        nl_word.end_offset   = sat16(pos_inc(pos_reg));
        nl_word.start_line   = line_reg;
        nl_word.start_column = col_reg;
        nl_word.last_result  = 1'b1;

        result.count  = 2'd0;
        result.first  = open_word;
        result.second = eof_word;

        if (is_end)
        begin
            if (mode_reg != tt_pkg::MODE_IDLE)
            begin
                result.count = 2'd2;
            end
            else
            begin
                result.count = 2'd1;
                result.first = eof_word;
            end
        end
        else if (quote_close)
        begin
            result.count             = 2'd1;
            result.first.last_result = 1'b1;
        end
        else if (closing && c_nl)
        begin
            result.count  = 2'd2;
            result.second = nl_word;
        end
        else if (closing)
        begin
            result.count             = 2'd1;
            result.first.last_result = 1'b1;
        end
        else if (opening && c_nl)
        begin
            result.count = 2'd1;
            result.first = nl_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            tbeg_reg  <= '0;
            line_reg  <= 16'd1;
            col_reg   <= 16'd1;
            tline_reg <= 16'd1;
            tcol_reg  <= 16'd1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            tbeg_reg  <= tbeg_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
        end
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg != 16'd0) && (col_reg != 16'd0))
        else $error("line or column counter reached zero");

    a_begin_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != tt_pkg::MODE_IDLE) |-> (tbeg_reg <= pos_reg))
        else $error("open token begins after the current offset");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_end) |=> (mode_reg == tt_pkg::MODE_IDLE) && (pos_reg == '0))
        else $error("end of text did not return the scanner to its start state");

endmodule

@@ design/tt_result_buffer.sv @@
`timescale 1ns / 1ps

module tt_result_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tt_pkg::scan_result_t result,
    output logic                 can_load,
    output logic                 token_valid,
    input  logic                 token_ready,
    output tt_pkg::out_word_t    token_word
);

    logic [1:0]        cnt_reg;
    tt_pkg::out_word_t slot0_reg;
    tt_pkg::out_word_t slot1_reg;
    logic              pop;

    assign token_valid = (cnt_reg != 2'd0);
    assign token_word  = slot0_reg;
    assign pop         = token_valid && token_ready;
    assign can_load    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= result.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= result.first;
            slot1_reg <= result.second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer holds more than two words");

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result buffer loaded while still occupied");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (!slot0_reg.last_result && slot1_reg.last_result))
        else $error("word pair has its last mark in the wrong place");

endmodule
